[rtl/htq_pkg.sv]
package htq_pkg;

  localparam int MAX_MAP_SIZE = 256;
  localparam int COORD_W      = 8;
  localparam int NUM_BANKS    = 4;
  localparam int BANK_DEPTH   = MAX_MAP_SIZE * MAX_MAP_SIZE / NUM_BANKS;
  localparam int BANK_AW      = 2 * (COORD_W - 1);
  localparam int DIV_STEPS    = 8;
  localparam int RND_STEPS    = 16;
  localparam int NUM_STAGES   = DIV_STEPS + RND_STEPS + 6;

  localparam logic [15:0] HEIGHT_BIAS = 16'd16384;

  typedef enum logic [1:0] {
    REG_MAP_SIZE  = 2'd0,
    REG_CELL_SIZE = 2'd1,
    REG_ORIGIN_X  = 2'd2,
    REG_ORIGIN_Z  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [7:0]         load_col;
    logic [7:0]         load_row;
    logic [7:0]         pixel_value;
    logic signed [23:0] query_x;
    logic signed [23:0] query_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               out_of_range;
  } out_word_t;

  typedef logic signed [15:0] pix_tbl_t [256];

  // pixel byte to signed q8.8 height, p*(p/255-0.5) rounded to nearest
  function automatic pix_tbl_t build_pix_tbl();
    pix_tbl_t tb;
    longint   n;
    for (int i = 0; i < 256; i++) begin
      n = 256 * longint'(i) * longint'(i) - 32640 * longint'(i);
      if (n >= 0) begin
        tb[i] = 16'((n + 127) / 255);
      end else begin
        tb[i] = 16'(-((-n + 127) / 255));
      end
    end
    return tb;
  endfunction

  localparam pix_tbl_t PIX_TBL = build_pix_tbl();

endpackage

[rtl/heightmap_terrain_height_query.sv]
// channel | valid    | stall     | word
// --------+----------+-----------+----------------------------------------
// input   | in_valid | in_stall  | in_word: load pixel or height query
// output  | out_valid| out_stall | out_word: height, out_of_range
// config  | cfg_we   | (none)    | cfg_index, cfg_data
//
// one word per cycle sustained unless the output stalls; each query gives a result word
// the pipeline holds the 8-step cell divider and the 16-step rounding divider
// reset is synchronous; the height store is not cleared and holds junk until loaded
// each stage moves when it or the stage after it is free, so bubbles collapse
// and input keeps flowing while a result waits on a stalled output
module heightmap_terrain_height_query (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  htq_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output htq_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import htq_pkg::*;

  typedef struct packed {
    logic               op;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [15:0] pixh;
    logic               outside;
    logic [23:0]        remx;
    logic [23:0]        remz;
    logic [7:0]         qx;
    logic [7:0]         qz;
  } div_t;

  typedef struct packed {
    logic        outside;
    logic [40:0] rem;
    logic [15:0] q;
  } rdiv_t;

  // stage numbering: 0 input, 1..8 cell divider, 9 store read, 10 select,
  // 11 multiply, 12 numerator, 13..28 rounding divider, 29 output
  localparam int ST_MEM = DIV_STEPS + 1;
  localparam int ST_SEL = DIV_STEPS + 2;
  localparam int ST_MUL = DIV_STEPS + 3;
  localparam int ST_RD0 = DIV_STEPS + 4;
  localparam int ST_OUT = NUM_STAGES - 1;

  // configuration registers
  logic [8:0]         map_size;
  logic [22:0]        cell_size;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_z;
  logic [30:0]        lim;
  logic [30:0]        lim_next;
  logic [22:0]        t_eff;
  logic [7:0]         mm1;

  // pipeline control
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  // stage payloads
  logic               a_op;
  logic [7:0]         a_col;
  logic [7:0]         a_row;
  logic signed [15:0] a_pixh;
  logic signed [24:0] a_tx;
  logic signed [24:0] a_tz;
  div_t               dv0;
  div_t               dv [1:DIV_STEPS];

  logic [15:0]        m_h [NUM_BANKS];
  logic               m_outside;
  logic [22:0]        m_rx;
  logic [22:0]        m_rz;
  logic               m_gx0;
  logic               m_gz0;

  logic signed [15:0] p_ha, p_hb, p_hc;
  logic [22:0]        p_wa, p_wb, p_wc;
  logic               p_outside;

  logic signed [39:0] q_pa, q_pb, q_pc;
  logic               q_outside;

  rdiv_t              rd [0:RND_STEPS];
  rdiv_t              rd0_next;

  logic [NUM_BANKS-1:0] bank_we;
  logic                 rd_en;

  out_word_t          out_reg;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      map_size  <= 9'd256;
      cell_size <= 23'd256;
      origin_x  <= '0;
      origin_z  <= '0;
      lim       <= 31'(256 * 255);
    end else begin
      lim <= lim_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MAP_SIZE:  map_size  <= cfg_data[8:0];
          REG_CELL_SIZE: cell_size <= cfg_data[22:0];
          REG_ORIGIN_X:  origin_x  <= cfg_data;
          REG_ORIGIN_Z:  origin_z  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // clamp map size to [2, 256] and a zero cell size to one
  always_comb begin
    t_eff = (cell_size == '0) ? 23'd1 : cell_size;
    if (map_size < 9'd2) begin
      mm1 = 8'd1;
    end else if (map_size > 9'(MAX_MAP_SIZE)) begin
      mm1 = 8'(MAX_MAP_SIZE - 1);
    end else begin
      mm1 = 8'(map_size - 9'd1);
    end
    // world extent of the grid in use, at or past which a query is outside
    lim_next = 31'(t_eff) * 31'(mm1);
  end

  // ---------------------------------------------------------- flow control
  assign en[ST_OUT] = !vld[ST_OUT] || !out_stall;
  genvar g;
  generate
    for (g = 0; g < ST_OUT; g++) begin : g_en
      assign en[g] = !vld[g] || en[g+1];
    end
  endgenerate
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          // loads retire once written to the store
          if (k == ST_MEM) begin
            vld[k] <= vld[k-1] && dv[DIV_STEPS].op;
          end else begin
            vld[k] <= vld[k-1];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------- input stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_op   <= in_word.operation;
      a_col  <= in_word.load_col;
      a_row  <= in_word.load_row;
      a_pixh <= PIX_TBL[in_word.pixel_value];
      a_tx   <= 25'(in_word.query_x) - 25'(origin_x);
      a_tz   <= 25'(in_word.query_z) - 25'(origin_z);
    end
  end

  // outside test and divider seed
  always_comb begin
    dv0.op      = a_op;
    dv0.col     = a_col;
    dv0.row     = a_row;
    dv0.pixh    = a_pixh;
    dv0.outside = a_tx[24] || a_tz[24] ||
                  (31'(a_tx[23:0]) >= lim) || (31'(a_tz[23:0]) >= lim);
    dv0.remx    = a_tx[23:0];
    dv0.remz    = a_tz[23:0];
    dv0.qx      = '0;
    dv0.qz      = '0;
  end

  // ------------------------------------------------ cell index divider
  // restoring division, one quotient bit of each axis per stage
  generate
    for (g = 1; g <= DIV_STEPS; g++) begin : g_div
      localparam int B = DIV_STEPS - g;
      div_t        prv;
      div_t        nxt;
      logic [30:0] cmpv;
      if (g == 1) begin : g_first
        assign prv = dv0;
      end else begin : g_rest
        assign prv = dv[g-1];
      end
      always_comb begin
        cmpv = 31'(t_eff) << B;
        nxt  = prv;
        if (31'(prv.remx) >= cmpv) begin
          nxt.remx  = 24'(31'(prv.remx) - cmpv);
          nxt.qx[B] = 1'b1;
        end
        if (31'(prv.remz) >= cmpv) begin
          nxt.remz  = 24'(31'(prv.remz) - cmpv);
          nxt.qz[B] = 1'b1;
        end
      end
      always_ff @(posedge clk) begin
        if (en[g]) begin
          dv[g] <= nxt;
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------- height store
  // four banks by column and row parity, so the four cell corners come
  // from four different banks in the same cycle; loads write at the same
  // stage where queries read, which keeps store accesses in item order
  assign rd_en = en[ST_MEM] && vld[ST_MEM-1] && dv[DIV_STEPS].op;

  generate
    for (g = 0; g < NUM_BANKS; g++) begin : g_bank
      logic [15:0]        mem [BANK_DEPTH];
      logic [7:0]         rc;
      logic [7:0]         rr;
      logic [BANK_AW-1:0] raddr;
      logic [BANK_AW-1:0] waddr;

      // corner of this bank's parity: the cell origin or one past it
      assign rc    = dv[DIV_STEPS].qx + 8'(dv[DIV_STEPS].qx[0] ^ g[0]);
      assign rr    = dv[DIV_STEPS].qz + 8'(dv[DIV_STEPS].qz[0] ^ g[1]);
      assign raddr = {rr[7:1], rc[7:1]};
      assign waddr = {dv[DIV_STEPS].row[7:1], dv[DIV_STEPS].col[7:1]};
      assign bank_we[g] = en[ST_MEM] && vld[ST_MEM-1] && !dv[DIV_STEPS].op &&
                          (dv[DIV_STEPS].row[0] == g[1]) &&
                          (dv[DIV_STEPS].col[0] == g[0]);

      always_ff @(posedge clk) begin
        if (bank_we[g]) begin
          mem[waddr] <= dv[DIV_STEPS].pixh;
        end
        if (rd_en) begin
          m_h[g] <= mem[raddr];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[ST_MEM]) begin
      m_outside <= dv[DIV_STEPS].outside;
      m_rx      <= dv[DIV_STEPS].remx[22:0];
      m_rz      <= dv[DIV_STEPS].remz[22:0];
      m_gx0     <= dv[DIV_STEPS].qx[0];
      m_gz0     <= dv[DIV_STEPS].qz[0];
    end
  end

  // ---------------------------------------------------- triangle select
  logic [23:0] s_sum;
  logic        s_upper;
  logic [15:0] h00, h10, h01, h11;

  always_comb begin
    h00     = m_h[{m_gz0, m_gx0}];
    h10     = m_h[{m_gz0, !m_gx0}];
    h01     = m_h[{!m_gz0, m_gx0}];
    h11     = m_h[{!m_gz0, !m_gx0}];
    s_sum   = 24'(m_rx) + 24'(m_rz);
    s_upper = s_sum > 24'(t_eff);
  end

  always_ff @(posedge clk) begin
    if (en[ST_SEL]) begin
      p_outside <= m_outside;
      p_hb      <= h10;
      p_hc      <= h01;
      if (s_upper) begin
        p_ha <= h11;
        p_wa <= 23'(s_sum - 24'(t_eff));
        p_wb <= t_eff - m_rz;
        p_wc <= t_eff - m_rx;
      end else begin
        p_ha <= h00;
        p_wa <= 23'(24'(t_eff) - s_sum);
        p_wb <= m_rx;
        p_wc <= m_rz;
      end
    end
  end

  // ------------------------------------------------------------ weighting
  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      q_outside <= p_outside;
      q_pa      <= p_ha * $signed({1'b0, p_wa});
      q_pb      <= p_hb * $signed({1'b0, p_wb});
      q_pc      <= p_hc * $signed({1'b0, p_wc});
    end
  end

  // numerator for round-half-up division, biased so it stays positive
  logic signed [40:0] num;
  logic [41:0]        an;

  always_comb begin
    num = 41'(q_pa) + 41'(q_pb) + 41'(q_pc);
    an  = {num, 1'b0} + 42'(t_eff) + (42'(t_eff) << 15);
    rd0_next.outside = q_outside;
    rd0_next.rem     = an[40:0];
    rd0_next.q       = '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_RD0]) begin
      rd[0] <= rd0_next;
    end
  end

  // ------------------------------------------------ rounding divider
  generate
    for (g = 1; g <= RND_STEPS; g++) begin : g_rnd
      localparam int B = RND_STEPS - g;
      rdiv_t       nxt;
      logic [40:0] cmpv;
      always_comb begin
        cmpv = 41'({t_eff, 1'b0}) << B;
        nxt  = rd[g-1];
        if (rd[g-1].rem >= cmpv) begin
          nxt.rem  = rd[g-1].rem - cmpv;
          nxt.q[B] = 1'b1;
        end
      end
      always_ff @(posedge clk) begin
        if (en[ST_RD0 + g]) begin
          rd[g] <= nxt;
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_reg.out_of_range <= rd[RND_STEPS].outside;
      out_reg.height       <= rd[RND_STEPS].outside ? 16'sd0 :
                              $signed(rd[RND_STEPS].q - HEIGHT_BIAS);
    end
  end

  assign out_valid = vld[ST_OUT];
  assign out_word  = out_reg;

  // ---------------------------------------------------------- checks
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_of_range |-> out_word.height == 16'sd0)
    else $error("out of range result with nonzero height");

  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bank_we))
    else $error("more than one bank written");

  a_no_rw_mix: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && (bank_we != '0)))
    else $error("store read and write in the same cycle");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> !in_stall)
    else $error("input stalled with empty first stage");

endmodule

[dv/heightmap_terrain_height_query_test.sv]
`timescale 1ns / 100ps

module heightmap_terrain_height_query_test;
  import htq_pkg::*;

  localparam int STORE_SIDE = 256;
  localparam int DRAIN_WAIT = 40;     // pipeline is 30 deep, loads give no word
  localparam int LONG_HOLD  = 300;    // receiver hold-off, enough to fill the pipe

  // scoreboard: own copy of the store and registers, predicts each query word
  class height_scoreboard;
    logic signed [15:0] grid [STORE_SIDE*STORE_SIDE];
    bit                 loaded [STORE_SIDE*STORE_SIDE];
    longint             map_sz, cell_sz, org_x, org_z;
    out_word_t          awaited [$];
    int                 errors;
    int                 checked;

    function new();
      map_sz  = 256;
      cell_sz = 256;
      org_x   = 0;
      org_z   = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] d);
      case (idx)
        REG_MAP_SIZE:  map_sz  = longint'(d[8:0]);
        REG_CELL_SIZE: cell_sz = longint'(d[22:0]);
        REG_ORIGIN_X:  org_x   = longint'(signed'(d));
        REG_ORIGIN_Z:  org_z   = longint'(signed'(d));
        default: ;
      endcase
    endfunction

    function int eff_map();
      if (map_sz < 2) return 2;
      if (map_sz > STORE_SIDE) return STORE_SIDE;
      return int'(map_sz);
    endfunction

    function longint eff_cell();
      return (cell_sz < 1) ? 1 : cell_sz;
    endfunction

    // q8.8 height of a raw pixel byte, rounded to nearest
    function logic signed [15:0] pixel_to_height(logic [7:0] p);
      longint n;
      n = 256 * longint'(p) * longint'(p) - 32640 * longint'(p);
      if (n >= 0) return 16'((n + 127) / 255);
      return 16'(-((-n + 127) / 255));
    endfunction

    // cell and remainders of a world point; 0 when outside the grid
    function bit locate(logic signed [23:0] x, logic signed [23:0] z,
                        output int gx, output int gz,
                        output longint rx, output longint rz);
      longint tx, tz, t;
      t  = eff_cell();
      tx = longint'(x) - org_x;
      tz = longint'(z) - org_z;
      gx = 0; gz = 0; rx = 0; rz = 0;
      if (tx < 0 || tz < 0) return 0;
      if (tx / t >= eff_map() - 1 || tz / t >= eff_map() - 1) return 0;
      gx = int'(tx / t);
      gz = int'(tz / t);
      rx = tx % t;
      rz = tz % t;
      return 1;
    endfunction

    // a query is safe when it reads no store entry that was never loaded
    function bit safe_query(logic signed [23:0] x, logic signed [23:0] z);
      int     gx, gz;
      longint rx, rz;
      if (!locate(x, z, gx, gz, rx, rz)) return 1;
      return loaded[gz*STORE_SIDE + gx] && loaded[gz*STORE_SIDE + gx + 1] &&
             loaded[(gz+1)*STORE_SIDE + gx] && loaded[(gz+1)*STORE_SIDE + gx + 1];
    endfunction

    function longint at(int c, int r);
      return longint'(grid[r*STORE_SIDE + c]);
    endfunction

    // round to nearest, ties toward plus infinity
    function longint div_nearest(longint num, longint den);
      longint a, d, q;
      a = 2 * num + den;
      d = 2 * den;
      q = a / d;
      if ((a % d) != 0 && a < 0) q -= 1;
      return q;
    endfunction

    function void note_input(in_word_t w);
      int        gx, gz;
      longint    rx, rz, t, num;
      out_word_t e;
      if (op_t'(w.operation) == OP_LOAD) begin
        grid[w.load_row*STORE_SIDE + w.load_col]   = pixel_to_height(w.pixel_value);
        loaded[w.load_row*STORE_SIDE + w.load_col] = 1;
        return;
      end
      e = '0;
      if (!locate(w.query_x, w.query_z, gx, gz, rx, rz)) begin
        e.out_of_range = 1'b1;
      end else begin
        t = eff_cell();
        if (rx + rz <= t) begin
          num = at(gx, gz) * (t - rx - rz) + at(gx+1, gz) * rx + at(gx, gz+1) * rz;
        end else begin
          num = at(gx+1, gz) * (t - rz) + at(gx+1, gz+1) * (rx + rz - t) +
                at(gx, gz+1) * (t - rx);
        end
        e.height = 16'(div_nearest(num, t));
      end
      awaited = {awaited, e};
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(out_word_t r);
      out_word_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word height=%0d oor=%0b", r.height, r.out_of_range));
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (r.height !== e.height)
        report($sformatf("height got %0d want %0d", r.height, e.height));
      if (r.out_of_range !== e.out_of_range)
        report($sformatf("out_of_range got %0b want %0b", r.out_of_range, e.out_of_range));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  height_scoreboard sb = new();
  bit quiet     = 0;    // no idling on either side in the closing phase
  bit hold_long = 0;    // request for one long receiver hold-off
  int n_loads   = 0;
  int n_queries = 0;

  heightmap_terrain_height_query DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // generous upper bound on the whole run
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // result monitor: a word moves when valid and not stalled at the edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_word);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one word and hold it until taken, then maybe idle for a burst
  task send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    if (op_t'(w.operation) == OP_LOAD) n_loads++;
    else n_queries++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task load_pixel(int c, int r, int p);
    in_word_t    w;
    logic [95:0] junk;
    junk          = {$urandom, $urandom, $urandom};
    w             = in_word_t'(junk[$bits(in_word_t)-1:0]);   // junk query fields
    w.operation   = OP_LOAD;
    w.load_col    = 8'(c);
    w.load_row    = 8'(r);
    w.pixel_value = 8'(p);
    send_word(w);
  endtask

  task query_at(longint x, longint z);
    in_word_t    w;
    logic [95:0] junk;
    junk        = {$urandom, $urandom, $urandom};
    w           = in_word_t'(junk[$bits(in_word_t)-1:0]);     // junk load fields
    w.operation = OP_QUERY;
    w.query_x   = 24'(x);
    w.query_z   = 24'(z);
    send_word(w);
  endtask

  // write enable stays high across back to back writes, caller drops it
  task write_reg(cfg_reg_t idx, longint value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 24'(value);
    @(posedge clk);
    sb.set_reg(idx, 24'(value));
  endtask

  // let every expected word come back, then wait out the pipeline
  task drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task set_terrain(longint m, longint t, longint ox, longint oz);
    drain();
    write_reg(REG_MAP_SIZE, m);
    write_reg(REG_CELL_SIZE, t);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Z, oz);
    cfg_we <= 1'b0;
  endtask

  // world coordinate inside loaded cell g on one axis, or a random point past the origin if that leaves 24 bits
  function longint axis_point(int g, longint rem, longint org);
    longint p;
    p = longint'(g) * sb.eff_cell() + rem + org;
    if (p > 8388607) p = org + longint'($urandom_range(0, int'(8388607 - org)));
    return p;
  endfunction

  // one phase: load the corner patch, then a random mix of queries and loads
  task run_phase(int n_items);
    int     k, gx, gz;
    longint t, rx, rz, x, z;
    k = (sb.eff_map() < 9) ? sb.eff_map() : 9;
    t = sb.eff_cell();
    for (int r = 0; r < k; r++)
      for (int c = 0; c < k; c++)
        load_pixel(c, r, $urandom_range(0, 255));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        load_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else if ($urandom_range(0, 6) == 0) begin
        // noise over the whole coordinate range, unless it reads an unloaded point
        x = longint'(signed'(24'($urandom)));
        z = longint'(signed'(24'($urandom)));
        if (!sb.safe_query(24'(x), 24'(z))) begin
          x = sb.org_x - 1;
          if (x < -8388608) x = 8388607;
          z = sb.org_z;
        end
        if (!sb.safe_query(24'(x), 24'(z))) begin
          x = sb.org_x;
          z = sb.org_z;
        end
        query_at(x, z);
      end else begin
        gx = $urandom_range(0, k - 2);
        gz = $urandom_range(0, k - 2);
        rx = (t > 1) ? longint'($urandom_range(0, int'(t - 1))) : 0;
        rz = (t > 1) ? longint'($urandom_range(0, int'(t - 1))) : 0;
        // land on the diagonal between the two triangles now and then
        if ($urandom_range(0, 7) == 0 && rx > 0) rz = t - rx;
        query_at(axis_point(gx, rx, sb.org_x), axis_point(gz, rz, sb.org_z));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset registers, pixel extremes, both triangles, edges of the grid
    load_pixel(0, 0, 0);
    load_pixel(1, 0, 255);
    load_pixel(0, 1, 128);
    load_pixel(1, 1, 127);
    load_pixel(254, 254, 1);
    load_pixel(255, 254, 64);
    load_pixel(254, 255, 200);
    load_pixel(255, 255, 255);
    query_at(0, 0);
    query_at(128, 128);              // on the diagonal
    query_at(200, 20);               // lower triangle
    query_at(200, 220);              // upper triangle
    query_at(255, 255);
    query_at(-1, 0);
    query_at(0, -1);
    query_at(254*256 + 100, 254*256 + 50);
    query_at(254*256 + 250, 254*256 + 240);
    query_at(255*256, 0);            // last column is an edge, not a cell
    query_at(8388607, 8388607);
    query_at(-8388608, -8388608);
    query_at(0, 8388607);

    // settings sweep: map size clamping, zero and max cell, extreme origins
    set_terrain(2, 1, 0, 0);                       run_phase(110);
    set_terrain(4, 0, -100, 50);                   run_phase(110);
    set_terrain(9, 8388607, -8388608, -8388608);   run_phase(110);
    set_terrain(256, 300, 8388607, -5);
    fork
      run_phase(140);
      begin
        repeat (60) @(posedge clk);
        hold_long = 1;
      end
    join
    set_terrain(1, 77, 1234, -1234);               run_phase(110);
    set_terrain(511, 1000, -8388608, 8388607);     run_phase(110);
    set_terrain(0, 513, longint'(signed'(24'($urandom))), longint'(signed'(24'($urandom))));
    run_phase(110);
    set_terrain(6, 2, -3, 7);                      run_phase(110);
    quiet = 1;
    set_terrain(256, 256, 0, 0);                   run_phase(120);

    drain();
    $display("run covered %0d loads and %0d queries, %0d height words checked",
             n_loads, n_queries, sb.checked);
    $display("map sizes 0..511 with clamping, cell sizes 0..8388607, extreme origins");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
